>>> src/i2c_master_bit_engine_core_defines.svh
// Assertion macros shared by the I2C master bit engine checker.
`ifndef I2C_MASTER_BIT_ENGINE_CORE_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_CORE_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define I2CM_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define I2CM_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/i2cm_pkg.sv
// Shared types and constants of the I2C master bit engine.
`default_nettype none
package i2cm_pkg;

   // Width of the phase counter (also the used part of the half period) and of the half period.
   localparam int DIV_WIDTH = 16;
   localparam int HP_WIDTH = 16;
   localparam logic [HP_WIDTH-1:0] HP_RESET = 16'd250;

   // Command codes.
   localparam logic [2:0] OP_START = 3'd0;
   localparam logic [2:0] OP_STOP  = 3'd1;
   localparam logic [2:0] OP_WRITE = 3'd2;
   localparam logic [2:0] OP_READ  = 3'd3;
   localparam logic [2:0] OP_CHECK = 3'd4;
   localparam logic [2:0] OP_ACK   = 3'd5;
   localparam logic [2:0] OP_NACK  = 3'd6;
   localparam logic [2:0] OP_NONE  = 3'd7;

   // Bit index of the first bit sent or received.
   localparam logic [2:0] MSB_INDEX = 3'd7;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // One classified tick as it travels through the queue.
   typedef struct packed {
      logic       cmd_ok;
      logic [2:0] op;
      logic [7:0] wbyte;
      logic       sda;
   } item_type;

   // Fill status of the queue.
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage
`default_nettype wire

>>> src/i2cm_front.sv
// Front end: accepts ticks and classifies the offered command.
`default_nettype none
module i2cm_front
   import i2cm_pkg::*;
(
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic         req_cmd_valid,
   input  wire logic [2:0]   req_op,
   input  wire logic [7:0]   req_write_byte,
   input  wire logic         req_sda_in,
   input  wire q_status_type q_status,
   output logic              push,
   output item_type          push_item
);

   // The queue takes an item whenever it has room.
   assign req_ready = !q_status.full;
   assign push      = req_valid && !q_status.full;

   // A command counts only when offered with a meaningful code.
   always_comb begin
      push_item.cmd_ok = req_cmd_valid && (req_op != OP_NONE);
      push_item.op     = req_op;
      push_item.wbyte  = req_write_byte;
      push_item.sda    = req_sda_in;
   end

endmodule
`default_nettype wire

>>> src/i2cm_queue.sv
// Short item queue between the front end and the sequencer.
`default_nettype none
module i2cm_queue
   import i2cm_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   input  wire logic     pop,
   output item_type      pop_item,
   output q_status_type  q_status
);

   item_type                q_mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wptr_ff, wptr_in;
   logic [QUEUE_PTR_W-1:0]  rptr_ff, rptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;

   // Pointer and fill count updates.
   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Entry storage; needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wptr_ff] <= push_item;
      end
   end

   assign pop_item       = q_mem_ff[rptr_ff];
   assign q_status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);

endmodule
`default_nettype wire

>>> src/i2cm_back.sv
// Back end: the bus sequencer that runs one tick per item and registers the result.
`default_nettype none
module i2cm_back
   import i2cm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [HP_WIDTH-1:0] csr_wr_data,
   input  wire q_status_type        q_status,
   input  wire item_type            pop_item,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_scl_out,
   output logic                     rsp_sda_out,
   output logic                     rsp_busy_res,
   output logic                     rsp_done_res,
   output logic [7:0]               rsp_read_byte,
   output logic                     rsp_ack_seen
);

   // Sequence codes: idle, or phase number plus one.
   localparam logic [1:0] SEQ_IDLE = 2'd0;
   localparam logic [1:0] SEQ_PH0  = 2'd1;

   // Phase numbers within a command.
   localparam logic [1:0] PH_FIRST  = 2'd0;
   localparam logic [1:0] PH_SECOND = 2'd1;
   localparam logic [1:0] PH_THIRD  = 2'd2;

   typedef struct packed {
      logic ok;
      logic scl;
      logic sda;
      logic long_hold;
   } phase_type;

   logic [HP_WIDTH-1:0]  hp_ff, hp_in;
   logic [DIV_WIDTH-1:0] pc_ff, pc_in;
   logic [1:0]           seq_ff, seq_in;
   logic [2:0]           op_ff, op_in;
   logic [2:0]           bit_ff, bit_in;
   logic [7:0]           tx_ff, tx_in;
   logic [7:0]           rx_ff, rx_in;
   logic                 ack_ff, ack_in;
   logic                 scl_ff, scl_in;
   logic                 sda_ff, sda_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_scl_ff, rsp_sda_ff, rsp_busy_ff, rsp_done_ff, rsp_ack_ff;
   logic [7:0]           rsp_rbyte_ff;

   logic [DIV_WIDTH-1:0] hold;
   logic                 start, busy, done;
   logic [1:0]           seq_a, ph, nxt;
   logic [2:0]           op_a, bit_a;
   logic [7:0]           tx_a, rx_a;
   logic                 scl_a, sda_a;
   logic [DIV_WIDTH-1:0] pc_a, pc_dec;
   phase_type            ent0, ent1;
   logic [DIV_WIDTH-1:0] n_pc;
   logic [1:0]           n_seq;
   logic [2:0]           n_bit;
   logic [7:0]           n_rx;
   logic                 n_ack, n_scl, n_sda;

   // Levels and hold kind on entering a phase of a command.
   function automatic phase_type enter_phase(input logic [2:0] op, input logic [1:0] phase,
                                             input logic [2:0] bidx, input logic [7:0] tx,
                                             input logic scl_cur, input logic sda_cur);
      phase_type p;
      p.ok        = 1'b1;
      p.scl       = scl_cur;
      p.sda       = sda_cur;
      p.long_hold = 1'b1;
      unique case (op)
         OP_START: begin
            unique case (phase)
               PH_FIRST: begin
                  p.scl = 1'b1;
                  p.sda = 1'b1;
               end
               PH_SECOND: begin
                  p.scl       = 1'b1;
                  p.sda       = 1'b0;
                  p.long_hold = 1'b0;
               end
               PH_THIRD: begin
                  p.scl = 1'b0;
                  p.sda = 1'b0;
               end
               default: p.ok = 1'b0;
            endcase
         end
         OP_STOP: begin
            unique case (phase)
               PH_FIRST: begin
                  p.sda       = 1'b0;
                  p.long_hold = 1'b0;
               end
               PH_SECOND: begin
                  p.scl = 1'b1;
                  p.sda = 1'b0;
               end
               default: p.ok = 1'b0;
            endcase
         end
         default: begin
            unique case (phase)
               PH_FIRST: begin
                  p.scl = 1'b1;
                  if (op == OP_WRITE) begin
                     p.sda = tx[bidx];
                  end else if (op == OP_ACK) begin
                     p.sda = 1'b0;
                  end else begin
                     p.sda = 1'b1;
                  end
               end
               PH_SECOND: p.scl = 1'b0;
               default:   p.ok  = 1'b0;
            endcase
         end
      endcase
      return p;
   endfunction

   // A zero half period is taken as one tick.
   assign hold = (hp_ff[DIV_WIDTH-1:0] == '0) ? DIV_WIDTH'(1) : hp_ff[DIV_WIDTH-1:0];

   // A tick is worked on when one is queued and the result register is free.
   assign pop = !q_status.empty && (!rsp_valid_ff || rsp_ready);

   // One tick of the sequencer: accept a command, then count down and step phases.
   always_comb begin
      start = (seq_ff == SEQ_IDLE) && pop_item.cmd_ok;
      op_a  = start ? pop_item.op : op_ff;
      tx_a  = start ? pop_item.wbyte : tx_ff;
      bit_a = start ? MSB_INDEX : bit_ff;
      rx_a  = (start && pop_item.op == OP_READ) ? 8'd0 : rx_ff;
      ent0  = enter_phase(pop_item.op, PH_FIRST, MSB_INDEX, pop_item.wbyte, scl_ff, sda_ff);
      seq_a = start ? SEQ_PH0 : seq_ff;
      scl_a = start ? ent0.scl : scl_ff;
      sda_a = start ? ent0.sda : sda_ff;
      pc_a  = start ? (ent0.long_hold ? hold : DIV_WIDTH'(1)) : pc_ff;
      busy  = (seq_a != SEQ_IDLE);

      pc_dec = (pc_a != '0) ? pc_a - 1'b1 : pc_a;
      ph     = seq_a - 1'b1;
      nxt    = ph + 1'b1;
      n_pc   = pc_a;
      n_seq  = seq_a;
      n_bit  = bit_a;
      n_rx   = rx_a;
      n_ack  = ack_ff;
      n_scl  = scl_a;
      n_sda  = sda_a;
      done   = 1'b0;
      ent1   = '0;

      if (busy) begin
         n_pc = pc_dec;
         if (pc_dec == '0) begin
            // Sample SDA on the last high tick of a read bit or an ack check.
            if (ph == PH_FIRST && op_a == OP_READ && pop_item.sda) begin
               n_rx[bit_a] = 1'b1;
            end
            if (ph == PH_FIRST && op_a == OP_CHECK) begin
               n_ack = !pop_item.sda;
            end
            // Loop back for the next bit of a byte.
            if (ph == PH_SECOND && (op_a == OP_WRITE || op_a == OP_READ) && bit_a != '0) begin
               n_bit = bit_a - 1'b1;
               nxt   = PH_FIRST;
            end
            ent1 = enter_phase(op_a, nxt, n_bit, tx_a, scl_a, sda_a);
            if (ent1.ok) begin
               n_scl = ent1.scl;
               n_sda = ent1.sda;
               n_pc  = ent1.long_hold ? hold : DIV_WIDTH'(1);
               n_seq = nxt + 1'b1;
            end else begin
               if (op_a == OP_STOP || op_a == OP_ACK) begin
                  n_sda = 1'b1;
               end
               n_seq = SEQ_IDLE;
               done  = 1'b1;
            end
         end
      end
   end

   // Sequencer state advances only when a tick is taken; the half period loads on a CSR write.
   always_comb begin
      hp_in  = csr_wr_en ? csr_wr_data : hp_ff;
      pc_in  = pop ? n_pc  : pc_ff;
      seq_in = pop ? n_seq : seq_ff;
      op_in  = pop ? op_a  : op_ff;
      bit_in = pop ? n_bit : bit_ff;
      tx_in  = pop ? tx_a  : tx_ff;
      rx_in  = pop ? n_rx  : rx_ff;
      ack_in = pop ? n_ack : ack_ff;
      scl_in = pop ? n_scl : scl_ff;
      sda_in = pop ? n_sda : sda_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hp_ff        <= HP_RESET;
         pc_ff        <= '0;
         seq_ff       <= SEQ_IDLE;
         op_ff        <= OP_START;
         bit_ff       <= '0;
         tx_ff        <= '0;
         rx_ff        <= '0;
         ack_ff       <= 1'b0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         hp_ff        <= hp_in;
         pc_ff        <= pc_in;
         seq_ff       <= seq_in;
         op_ff        <= op_in;
         bit_ff       <= bit_in;
         tx_ff        <= tx_in;
         rx_ff        <= rx_in;
         ack_ff       <= ack_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result register; loaded with the tick's outputs.
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_scl_ff   <= scl_a;
         rsp_sda_ff   <= sda_a;
         rsp_busy_ff  <= busy;
         rsp_done_ff  <= done;
         rsp_rbyte_ff <= n_rx;
         rsp_ack_ff   <= n_ack;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scl_out   = rsp_scl_ff;
   assign rsp_sda_out   = rsp_sda_ff;
   assign rsp_busy_res  = rsp_busy_ff;
   assign rsp_done_res  = rsp_done_ff;
   assign rsp_read_byte = rsp_rbyte_ff;
   assign rsp_ack_seen  = rsp_ack_ff;

endmodule
`default_nettype wire

>>> src/i2c_master_bit_engine_core.sv
// I2C master bit engine: top level joining front end, queue and sequencer.
// Each accepted tick is stored in the queue, then taken by the sequencer, whose outputs go to the result register.
// Throughput: one tick per cycle while the result register is free or being emptied.
// A two-entry queue decouples the input from result back-pressure.
// Reset is synchronous and active high; it sets a half period of 250 and both lines released.
`default_nettype none
module i2c_master_bit_engine_core
   import i2cm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_cmd_valid,
   input  wire logic [2:0]          req_op,
   input  wire logic [7:0]          req_write_byte,
   input  wire logic                req_sda_in,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_scl_out,
   output logic                     rsp_sda_out,
   output logic                     rsp_busy_res,
   output logic                     rsp_done_res,
   output logic [7:0]               rsp_read_byte,
   output logic                     rsp_ack_seen,
   input  wire logic                csr_wr_en,
   input  wire logic [HP_WIDTH-1:0] csr_wr_data
);

   q_status_type q_status;
   item_type     push_item;
   item_type     pop_item;
   logic         push;
   logic         pop;

   // Accept and classify ticks.
   i2cm_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd_valid  (req_cmd_valid),
      .req_op         (req_op),
      .req_write_byte (req_write_byte),
      .req_sda_in     (req_sda_in),
      .q_status       (q_status),
      .push           (push),
      .push_item      (push_item)
   );

   // Hold ticks between the two halves.
   i2cm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .q_status  (q_status)
   );

   // Run the bus sequence and register each result.
   i2cm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .q_status      (q_status),
      .pop_item      (pop_item),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_scl_out   (rsp_scl_out),
      .rsp_sda_out   (rsp_sda_out),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_done_res  (rsp_done_res),
      .rsp_read_byte (rsp_read_byte),
      .rsp_ack_seen  (rsp_ack_seen)
   );

endmodule
`default_nettype wire

>>> src/i2cm_checker.sv
// Port-level checks for the I2C master bit engine, bound to the top level.
`default_nettype none
`include "i2c_master_bit_engine_core_defines.svh"
module i2cm_checker
   import i2cm_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                req_cmd_valid,
   input wire logic [2:0]          req_op,
   input wire logic [7:0]          req_write_byte,
   input wire logic                req_sda_in,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic                rsp_scl_out,
   input wire logic                rsp_sda_out,
   input wire logic                rsp_busy_res,
   input wire logic                rsp_done_res,
   input wire logic [7:0]          rsp_read_byte,
   input wire logic                rsp_ack_seen,
   input wire logic                csr_wr_en,
   input wire logic [HP_WIDTH-1:0] csr_wr_data
);

   logic        rsp_stall;
   logic [13:0] rsp_held;

   // The result channel as one word, valid included.
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_held  = {rsp_valid, rsp_scl_out, rsp_sda_out, rsp_busy_res, rsp_done_res,
                       rsp_read_byte, rsp_ack_seen};

   // A stalled item is held with all its fields.
   `I2CM_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> $stable(rsp_held), "result not held")

   // A command can only finish on a tick on which it is running.
   `I2CM_ASSERT(a_done_busy, clock, reset, rsp_valid && rsp_done_res |-> rsp_busy_res, "bad done")

   // After reset no result is pending and the input side is open.
   `I2CM_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && req_ready, "reset not clean")

endmodule

bind i2c_master_bit_engine_core i2cm_checker u_checker (.*);
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the I2C master bit engine, with its own line-level predictor.
`timescale 1ns / 1ps
module testbench;
   import i2cm_pkg::*;

   // One tick offered to the engine.
   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] op;
      logic [7:0] wbyte;
      logic       sda;
   } bus_tick_type;

   // The line levels and status that the engine reports for one tick.
   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       busy;
      logic       done;
      logic [7:0] rbyte;
      logic       ack;
   } line_view_type;

   // SDA levels offered while a command runs.
   localparam int SDA_RANDOM = 0;
   localparam int SDA_LOW    = 1;
   localparam int SDA_HIGH   = 2;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_cmd_valid = 1'b0;
   logic [2:0]          req_op = OP_START;
   logic [7:0]          req_write_byte = 8'h00;
   logic                req_sda_in = 1'b1;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_scl_out;
   logic                rsp_sda_out;
   logic                rsp_busy_res;
   logic                rsp_done_res;
   logic [7:0]          rsp_read_byte;
   logic                rsp_ack_seen;
   logic                csr_wr_en = 1'b0;
   logic [HP_WIDTH-1:0] csr_wr_data = '0;

   // Ticks waiting to be driven and line views waiting to be seen.
   bus_tick_type  tick_queue[$];
   line_view_type expected_lines[$];
   int            ticks_built = 0;
   int            errors = 0;
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;

   // Predicted engine state, starting from its reset values.
   logic [HP_WIDTH-1:0] eng_half = HP_RESET;
   logic [15:0]         eng_count = '0;
   logic [3:0]          eng_bit = '0;
   logic [3:0]          eng_seq = '0;
   logic [2:0]          eng_op = OP_START;
   logic [7:0]          eng_tx = '0;
   logic [7:0]          eng_rx = '0;
   logic                eng_ack = 1'b0;
   logic                eng_scl = 1'b1;
   logic                eng_sda = 1'b1;

   i2c_master_bit_engine_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd_valid  (req_cmd_valid),
      .req_op         (req_op),
      .req_write_byte (req_write_byte),
      .req_sda_in     (req_sda_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_scl_out    (rsp_scl_out),
      .rsp_sda_out    (rsp_sda_out),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_ack_seen   (rsp_ack_seen),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Length of one SCL phase; a zero half period counts as one tick.
   function automatic logic [15:0] phase_ticks();
      return (eng_half == 0) ? 16'd1 : eng_half;
   endfunction

   // Set the line levels and phase length on entry to a phase of the running command.
   function automatic bit enter_phase(int unsigned ph);
      enter_phase = 1'b1;
      if (eng_op == OP_START) begin
         if (ph == 0) begin
            eng_scl = 1'b1; eng_sda = 1'b1; eng_count = phase_ticks();
         end else if (ph == 1) begin
            eng_scl = 1'b1; eng_sda = 1'b0; eng_count = 16'd1;
         end else if (ph == 2) begin
            eng_scl = 1'b0; eng_sda = 1'b0; eng_count = phase_ticks();
         end else begin
            enter_phase = 1'b0;
         end
      end else if (eng_op == OP_STOP) begin
         if (ph == 0) begin
            eng_sda = 1'b0; eng_count = 16'd1;
         end else if (ph == 1) begin
            eng_scl = 1'b1; eng_sda = 1'b0; eng_count = phase_ticks();
         end else begin
            enter_phase = 1'b0;
         end
      end else begin
         if (ph == 0) begin
            eng_scl = 1'b1;
            if (eng_op == OP_WRITE) eng_sda = eng_tx[eng_bit[2:0]];
            else if (eng_op == OP_ACK) eng_sda = 1'b0;
            else eng_sda = 1'b1;
            eng_count = phase_ticks();
         end else if (ph == 1) begin
            eng_scl = 1'b0; eng_count = phase_ticks();
         end else begin
            enter_phase = 1'b0;
         end
      end
   endfunction

   // Advance the predicted engine by one tick and return what it shows on that tick.
   function automatic line_view_type advance_engine(bus_tick_type t);
      line_view_type r;
      int unsigned   ph;
      int unsigned   nxt;
      if (eng_seq == 0 && t.cmd_valid && t.op != OP_NONE) begin
         eng_op = t.op;
         eng_tx = t.wbyte;
         eng_bit = {1'b0, MSB_INDEX};
         if (t.op == OP_READ) eng_rx = '0;
         eng_seq = 4'd1;
         void'(enter_phase(0));
      end
      r.busy = (eng_seq != 0);
      r.scl = eng_scl;
      r.sda = eng_sda;
      r.done = 1'b0;
      if (r.busy) begin
         if (eng_count > 0) eng_count = eng_count - 1'b1;
         if (eng_count == 0) begin
            ph = eng_seq - 1;
            nxt = ph + 1;
            // SDA is sampled on the last high tick of a read bit or an acknowledge check.
            if (ph == 0 && eng_op == OP_READ && t.sda) eng_rx[eng_bit[2:0]] = 1'b1;
            if (ph == 0 && eng_op == OP_CHECK) eng_ack = !t.sda;
            if (ph == 1 && (eng_op == OP_WRITE || eng_op == OP_READ) && eng_bit > 0) begin
               eng_bit = eng_bit - 1'b1;
               nxt = 0;
            end
            if (enter_phase(nxt)) begin
               eng_seq = 4'(nxt + 1);
            end else begin
               // Stop and send ack release SDA only after the finishing tick.
               if (eng_op == OP_STOP || eng_op == OP_ACK) eng_sda = 1'b1;
               eng_seq = '0;
               r.done = 1'b1;
            end
         end
      end
      r.rbyte = eng_rx;
      r.ack = eng_ack;
      return r;
   endfunction

   // Number of ticks a command keeps the engine busy at the current half period.
   function automatic int command_ticks(logic [2:0] op);
      int h;
      h = phase_ticks();
      case (op)
         OP_START: return 2 * h + 1;
         OP_STOP:  return h + 1;
         OP_WRITE, OP_READ: return 16 * h;
         default:  return 2 * h;
      endcase
   endfunction

   function automatic logic pick_sda(int mode);
      if (mode == SDA_LOW) return 1'b0;
      if (mode == SDA_HIGH) return 1'b1;
      return 1'($urandom_range(1));
   endfunction

   function automatic void queue_tick(logic cv, logic [2:0] op, logic [7:0] wb, logic sda);
      bus_tick_type t;
      t.cmd_valid = cv;
      t.op = op;
      t.wbyte = wb;
      t.sda = sda;
      tick_queue.push_back(t);
      ticks_built++;
   endfunction

   // Offer a command on an idle engine, then fill its run with ticks whose offers are ignored.
   // The finishing tick often carries an offer too, which must also be ignored.
   function automatic void queue_command(logic [2:0] op, logic [7:0] wb, int mode);
      int n;
      n = command_ticks(op);
      queue_tick(1'b1, op, wb, pick_sda(mode));
      for (int i = 1; i < n; i++) begin
         queue_tick((i == n - 1) ? 1'($urandom_range(1)) : ($urandom_range(3) == 0),
                    3'($urandom_range(7)), 8'($urandom), pick_sda(mode));
      end
   endfunction

   // Idle ticks: either no offer, or an offer of the meaningless op, which is ignored.
   function automatic void queue_noise(int n);
      logic cv;
      for (int i = 0; i < n; i++) begin
         cv = 1'($urandom_range(1));
         queue_tick(cv, cv ? OP_NONE : 3'($urandom_range(7)), 8'($urandom),
                    1'($urandom_range(1)));
      end
   endfunction

   // A well-formed transfer: start, address, acknowledge, data bytes, and usually a stop.
   function automatic void queue_transfer();
      logic [7:0] addr;
      int         nbytes;
      addr = 8'($urandom);
      nbytes = $urandom_range(1, 3);
      queue_command(OP_START, 8'($urandom), SDA_RANDOM);
      queue_command(OP_WRITE, addr, SDA_RANDOM);
      queue_command(OP_CHECK, 8'($urandom), SDA_RANDOM);
      for (int i = 0; i < nbytes; i++) begin
         if (addr[0]) begin
            queue_command(OP_READ, 8'($urandom), SDA_RANDOM);
            queue_command((i == nbytes - 1) ? OP_NACK : OP_ACK, 8'($urandom), SDA_RANDOM);
         end else begin
            queue_command(OP_WRITE, 8'($urandom), SDA_RANDOM);
            queue_command(OP_CHECK, 8'($urandom), SDA_RANDOM);
         end
      end
      if ($urandom_range(3) != 0) queue_command(OP_STOP, 8'($urandom), SDA_RANDOM);
   endfunction

   function automatic void queue_random(int budget);
      int first;
      first = ticks_built;
      while (ticks_built - first < budget) begin
         if ($urandom_range(3) == 0) queue_noise($urandom_range(0, 3));
         if ($urandom_range(4) != 0) queue_transfer();
         else queue_command(3'($urandom_range(6)), 8'($urandom), SDA_RANDOM);
      end
   endfunction

   // Wait until every tick has been taken and answered, with the engine idle again.
   task automatic settle();
      forever begin
         @(negedge clock);
         while (tick_queue.size() != 0 || req_valid || expected_lines.size() != 0)
            @(negedge clock);
         if (eng_seq == 0) break;
         queue_noise(eng_count + 2);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic write_half_period(logic [HP_WIDTH-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      eng_half = value;
   endtask

   task automatic set_idling(int mode);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
         default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
   endtask

   // Driver: predicts each accepted item, then offers the next pending one.
   bus_tick_type staged;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            staged.cmd_valid = req_cmd_valid;
            staged.op = req_op;
            staged.wbyte = req_write_byte;
            staged.sda = req_sda_in;
            expected_lines.push_back(advance_engine(staged));
         end
         if (!req_valid || req_ready) begin
            if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               staged = tick_queue.pop_front();
               req_valid <= 1'b1;
               req_cmd_valid <= staged.cmd_valid;
               req_op <= staged.op;
               req_write_byte <= staged.wbyte;
               req_sda_in <= staged.sda;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic void compare_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   // Monitor: each result item is checked against the oldest prediction.
   line_view_type want;
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_lines.size() == 0) begin
            $error("result item with no item outstanding");
            errors++;
         end else begin
            want = expected_lines.pop_front();
            compare_field("scl_out", want.scl, rsp_scl_out);
            compare_field("sda_out", want.sda, rsp_sda_out);
            compare_field("busy_res", want.busy, rsp_busy_res);
            compare_field("done_res", want.done, rsp_done_res);
            compare_field("read_byte", want.rbyte, rsp_read_byte);
            compare_field("ack_seen", want.ack, rsp_ack_seen);
         end
      end
   end

   // Stimulus sequence.
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset half period, no idling.
      set_idling(0);
      queue_command(OP_START, 8'h00, SDA_RANDOM);
      queue_noise(3);
      queue_command(OP_STOP, 8'hFF, SDA_RANDOM);
      settle();

      // Shortest phases: every op, both byte extremes and both acknowledge outcomes.
      write_half_period(16'd1);
      queue_command(OP_START, 8'h00, SDA_RANDOM);
      queue_command(OP_WRITE, 8'hFF, SDA_RANDOM);
      queue_command(OP_CHECK, 8'h00, SDA_LOW);
      queue_command(OP_WRITE, 8'h00, SDA_RANDOM);
      queue_command(OP_CHECK, 8'hFF, SDA_HIGH);
      queue_command(OP_READ, 8'h00, SDA_HIGH);
      queue_command(OP_ACK, 8'h00, SDA_RANDOM);
      queue_command(OP_READ, 8'hFF, SDA_LOW);
      queue_command(OP_NACK, 8'h00, SDA_RANDOM);
      queue_noise(4);
      queue_command(OP_READ, 8'h00, SDA_RANDOM);
      queue_command(OP_WRITE, 8'hA5, SDA_RANDOM);
      queue_command(OP_STOP, 8'h00, SDA_RANDOM);
      settle();

      // A zero half period behaves as one tick.
      write_half_period(16'd0);
      queue_command(OP_START, 8'h00, SDA_RANDOM);
      queue_command(OP_WRITE, 8'h5A, SDA_RANDOM);
      queue_command(OP_CHECK, 8'h00, SDA_RANDOM);
      queue_command(OP_STOP, 8'h00, SDA_RANDOM);
      settle();

      // Random transfers under each idling pattern, at small half periods.
      for (int p = 0; p < 8; p++) begin
         set_idling(p % 4);
         write_half_period((p == 5) ? 16'd5 : 16'($urandom_range(1, 3)));
         queue_random(30);
         settle();
      end

      if (errors == 0) begin
         $display("i2c_master_bit_engine_core: match");
      end else begin
         $display("i2c_master_bit_engine_core: mismatch");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #800000;
      $display("i2c_master_bit_engine_core: mismatch");
      $finish;
   end

endmodule

>>> sim.f
+incdir+src
src/i2cm_pkg.sv
src/i2cm_front.sv
src/i2cm_queue.sv
src/i2cm_back.sv
src/i2c_master_bit_engine_core.sv
src/i2cm_checker.sv
tb/sv/testbench.sv
